[sv/text_console_cell_writer_assert.svh]
// assertion macros for the text console cell writer
// expects clk and rst in the scope of use

`ifndef TEXT_CONSOLE_CELL_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_CELL_WRITER_ASSERT_SVH

// property holds in the same cycle as the trigger
`define TCCW_ASSERT_SAME(label, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (prop)) \
    else $error(msg);

// property holds in the cycle after the trigger
`define TCCW_ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) \
    else $error(msg);

`endif

[sv/tccw_pkg.sv]
// shared types and constants for the text console cell writer
// no dependencies
`timescale 1ns / 1ps

package tccw_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam int COL_W      = 7;
  localparam int ROW_W      = 5;
  localparam int CHAR_W     = 8;
  localparam int ATTR_W     = 8;
  localparam int CELL_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;

  localparam logic [COL_W-1:0] COL_MAX  = 7'd127;
  localparam logic [COL_W:0]   TAB_STEP = 8'd4;
  localparam logic [COL_W:0]   TAB_MASK = ~8'd3;

  typedef enum logic [1:0] {
    REQ_PUT   = 2'd0,
    REQ_SET   = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_READ  = 2'd3
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FLOOR_EN   = 3'd0,
    CFG_FLOOR_COL  = 3'd1,
    CFG_FLOOR_ROW  = 3'd2,
    CFG_FILL_ATTR  = 3'd3,
    CFG_CR_FLOOR   = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CALC,
    ST_TAB,
    ST_READ,
    ST_SCROLL,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    req_t              req_type;
    logic [CHAR_W-1:0] char_code;
    logic [ATTR_W-1:0] char_attribute;
    logic [COL_W-1:0]  target_col;
    logic [ROW_W-1:0]  target_row;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [CELL_W-1:0] cell_data;
    logic              scrolled;
  } out_item_t;

  typedef struct packed {
    logic              floor_enable;
    logic [COL_W-1:0]  floor_col;
    logic [ROW_W-1:0]  floor_row;
    logic [ATTR_W-1:0] fill_attribute;
    logic              cr_honours_floor;
  } cfg_t;

endpackage

[sv/tccw_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/tccw_cfg.sv]
// configuration register bank for the text console cell writer
// depends on tccw_pkg
`timescale 1ns / 1ps

module tccw_cfg import tccw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  index,
  input  logic [CFG_DATA_W-1:0] wdata,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.floor_enable     <= 1'b0;
      cfg.floor_col        <= '0;
      cfg.floor_row        <= '0;
      cfg.fill_attribute   <= 8'd7;
      cfg.cr_honours_floor <= 1'b0;
    end else if (wr_en) begin
      unique case (cfg_idx_t'(index))
        CFG_FLOOR_EN:  cfg.floor_enable     <= wdata[0];
        CFG_FLOOR_COL: cfg.floor_col        <= wdata[COL_W-1:0];
        CFG_FLOOR_ROW: cfg.floor_row        <= wdata[ROW_W-1:0];
        CFG_FILL_ATTR: cfg.fill_attribute   <= wdata[ATTR_W-1:0];
        CFG_CR_FLOOR:  cfg.cr_honours_floor <= wdata[0];
        default: ;
      endcase
    end
  end

endmodule

[sv/tccw_ctrl.sv]
// request sequencer: cursor, row rotation, cell writes and cell reads of the cell ram
// depends on tccw_pkg; drives one tccw_ram instance
`timescale 1ns / 1ps

module tccw_ctrl import tccw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS,
  localparam int TOTAL  = COLUMNS * ROWS,
  localparam int AW     = $clog2(TOTAL)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  in_item_t          req,
  input  cfg_t              cfg,
  output logic              done,
  output out_item_t         result,
  output logic              mem_we,
  output logic [AW-1:0]     mem_waddr,
  output logic [CELL_W-1:0] mem_wdata,
  output logic              mem_re,
  output logic [AW-1:0]     mem_raddr,
  input  logic [CELL_W-1:0] mem_rdata
);

  localparam int ROW_W1 = ROW_W + 1;

  state_t            state, state_next;
  in_item_t          req_q;
  logic [COL_W-1:0]  col, col_next;
  logic [ROW_W-1:0]  row, row_next;
  logic [ROW_W-1:0]  top, top_next;
  logic [AW-1:0]     sweep, sweep_next;
  logic [AW-1:0]     base, base_next;
  logic [COL_W-1:0]  tab_end, tab_end_next;
  logic [CELL_W-1:0] cell_q, cell_next;
  logic              scrolled_q, scrolled_next;
  logic              done_next;

  // decode
  logic              floor_hold;
  logic [COL_W:0]    col_inc;
  logic              col_wrap;
  logic [COL_W:0]    tab_sum;
  logic [COL_W-1:0]  tab_target;
  logic              row_last;
  logic [ROW_W-1:0]  top_wrap;
  logic              tcol_ok, trow_ok, rd_ok;
  logic              adv_line;
  logic              bs_move;
  logic              tab_last;
  logic              last_row_cell, last_cell;
  logic [COL_W-1:0]  acol;
  logic [ROW_W-1:0]  arow;
  logic [ROW_W:0]    psum;
  logic [ROW_W-1:0]  prow;
  logic [AW-1:0]     addr;
  logic              acol_on;

  always_comb begin
    floor_hold = cfg.floor_enable &&
                 ((row < cfg.floor_row) || (row == cfg.floor_row && col <= cfg.floor_col));
    col_inc    = {1'b0, col} + TAB_STEP[COL_W:0] - 8'd3;
    col_wrap   = col_inc >= (COL_W + 1)'(COLUMNS);
    tab_sum    = ({1'b0, col} + TAB_STEP) & TAB_MASK;
    tab_target = (tab_sum > {1'b0, COL_MAX}) ? COL_MAX : tab_sum[COL_W-1:0];
    row_last   = row == ROW_W'(ROWS - 1);
    top_wrap   = (top == ROW_W'(ROWS - 1)) ? '0 : top + ROW_W'(1);
    tcol_ok    = req_q.target_col < COL_W'(COLUMNS);
    trow_ok    = req_q.target_row < ROW_W'(ROWS);
    rd_ok      = tcol_ok && trow_ok;
    bs_move    = !floor_hold && (col != '0);
    tab_last   = col_inc[COL_W-1:0] == tab_end;
    // line feed, or any byte other than CR, tab and backspace that runs off the right edge
    case (req_q.char_code)
      CH_LF:                 adv_line = 1'b1;
      CH_CR, CH_TAB, CH_BS:  adv_line = 1'b0;
      default:               adv_line = col_wrap;
    endcase
    last_row_cell = sweep == AW'(COLUMNS - 1);
    last_cell     = sweep == AW'(TOTAL - 1);

    acol = col;
    arow = row;
    if (state == ST_CALC && req_q.req_type == REQ_READ) begin
      acol = req_q.target_col;
      arow = req_q.target_row;
    end else if (state == ST_CALC && req_q.char_code == CH_BS) begin
      acol = col - COL_W'(1);
    end
    // logical row to physical row through the rotating top pointer
    psum    = {1'b0, arow} + {1'b0, top};
    prow    = (psum >= ROW_W1'(ROWS)) ? ROW_W'(psum - ROW_W1'(ROWS)) : psum[ROW_W-1:0];
    addr    = AW'(prow) * AW'(COLUMNS) + AW'(acol);
    acol_on = acol < COL_W'(COLUMNS);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT:   if (last_cell) state_next = ST_IDLE;
      ST_IDLE:   if (start) state_next = ST_CALC;
      ST_CALC: begin
        case (req_q.req_type)
          REQ_PUT: begin
            if (req_q.char_code == CH_TAB && tab_target != col) begin
              state_next = ST_TAB;
            end else if (adv_line && row_last) begin
              state_next = ST_SCROLL;
            end else begin
              state_next = ST_IDLE;
            end
          end
          REQ_SET:   state_next = ST_IDLE;
          REQ_CLEAR: state_next = ST_CLEAR;
          default:   state_next = rd_ok ? ST_READ : ST_IDLE;
        endcase
      end
      ST_TAB:    if (tab_last) state_next = ST_IDLE;
      ST_READ:   state_next = ST_IDLE;
      ST_SCROLL: if (last_row_cell) state_next = ST_IDLE;
      ST_CLEAR:  if (last_cell) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // datapath and memory port
  always_comb begin
    col_next      = col;
    row_next      = row;
    top_next      = top;
    sweep_next    = sweep;
    base_next     = base;
    tab_end_next  = tab_end;
    cell_next     = cell_q;
    scrolled_next = scrolled_q;
    done_next     = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = addr;
    mem_wdata     = {req_q.char_attribute, CH_BLANK};
    mem_re        = 1'b0;
    mem_raddr     = addr;

    unique case (state)
      ST_INIT: begin
        mem_we     = 1'b1;
        mem_waddr  = sweep;
        mem_wdata  = '0;
        sweep_next = last_cell ? '0 : sweep + AW'(1);
      end
      ST_IDLE: ;
      ST_CALC: begin
        cell_next     = '0;
        scrolled_next = 1'b0;
        sweep_next    = '0;
        case (req_q.req_type)
          REQ_PUT: begin
            case (req_q.char_code)
              CH_LF: col_next = '0;
              CH_CR: begin
                if (!(cfg.cr_honours_floor && floor_hold)) col_next = '0;
              end
              CH_TAB: tab_end_next = tab_target;
              CH_BS: begin
                if (bs_move) begin
                  col_next = acol;
                  mem_we   = acol_on;
                end
              end
              default: begin
                mem_we    = acol_on;
                mem_wdata = {req_q.char_attribute, req_q.char_code};
                col_next  = col_wrap ? '0 : col_inc[COL_W-1:0];
              end
            endcase
            if (adv_line && row_last) begin
              // bottom row: rotate, then blank the row that becomes the new bottom
              top_next  = top_wrap;
              base_next = AW'(top) * AW'(COLUMNS);
            end else begin
              if (adv_line) row_next = row + ROW_W'(1);
              done_next = !(req_q.char_code == CH_TAB && tab_target != col);
            end
          end
          REQ_SET: begin
            if (tcol_ok) col_next = req_q.target_col;
            if (trow_ok) row_next = req_q.target_row;
            done_next = 1'b1;
          end
          REQ_CLEAR: begin
            col_next = '0;
            row_next = '0;
            top_next = '0;
          end
          default: begin
            mem_re    = rd_ok;
            done_next = !rd_ok;
          end
        endcase
      end
      ST_TAB: begin
        mem_we    = acol_on;
        col_next  = col_inc[COL_W-1:0];
        done_next = tab_last;
      end
      ST_READ: begin
        cell_next = mem_rdata;
        done_next = 1'b1;
      end
      ST_SCROLL: begin
        mem_we     = 1'b1;
        mem_waddr  = base + sweep;
        mem_wdata  = {cfg.fill_attribute, CH_BLANK};
        sweep_next = sweep + AW'(1);
        if (last_row_cell) begin
          done_next     = 1'b1;
          scrolled_next = 1'b1;
        end
      end
      ST_CLEAR: begin
        mem_we     = 1'b1;
        mem_waddr  = sweep;
        mem_wdata  = {cfg.fill_attribute, CH_BLANK};
        sweep_next = sweep + AW'(1);
        done_next  = last_cell;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      col   <= '0;
      row   <= '0;
      top   <= '0;
      sweep <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      col   <= col_next;
      row   <= row_next;
      top   <= top_next;
      sweep <= sweep_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      req_q <= req;
    end
    base       <= base_next;
    tab_end    <= tab_end_next;
    cell_q     <= cell_next;
    scrolled_q <= scrolled_next;
  end

  assign busy              = state != ST_IDLE;
  assign result.cursor_col = col;
  assign result.cursor_row = row;
  assign result.cell_data  = cell_q;
  assign result.scrolled   = scrolled_q;

endmodule

[sv/text_console_cell_writer.sv]
// put, set and an out-of-range read finish from the calc state; a read goes on to a
// read state, a tab that moves blanks each column it passes (up to 4), a line
// advance that scrolls blanks the new bottom row and clear blanks every cell; a new
// request is taken in the cycle done is high, not while a request is still in work.
// the sweeps go through the single write port of the cell ram, one cell per cycle.
// after reset busy stays high while the ram is zeroed.
`timescale 1ns / 1ps
`include "text_console_cell_writer_assert.svh"

module text_console_cell_writer import tccw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              req,
  output logic                  done,
  output out_item_t             result,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int TOTAL = COLUMNS * ROWS;
  localparam int AW    = $clog2(TOTAL);

  cfg_t              cfg;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata, mem_rdata;

  tccw_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .wr_en (cfg_wr_en),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  tccw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .cfg       (cfg),
    .done      (done),
    .result    (result),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  tccw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (TOTAL)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  `TCCW_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted request did not raise busy")
  `TCCW_ASSERT_SAME(a_done_idle, done, !busy && $past(busy), "done beat without prior work")
  `TCCW_ASSERT_SAME(a_row_range, done, result.cursor_row < ROW_W'(ROWS), "cursor row off screen")
  `TCCW_ASSERT_SAME(a_scroll_row, done && result.scrolled, result.cursor_row == ROW_W'(ROWS - 1), "scroll left cursor off bottom row")

endmodule
